### rtl/core/assert_macros.svh
// Assertion macros shared by the ARP reply filter RTL.
// Needs signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ARF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define ARF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define ARF_ASSERT(label, prop)
`define ARF_ASSERT_ALWAYS(label, prop)
`endif
`endif

### rtl/core/arf_pkg.sv
// Package for the ARP reply frame filter: field widths, status codes,
// register indexes, reset values and the structs passed between modules.
// No dependencies.
package arf_pkg;

  localparam int BYTE_W     = 8;
  localparam int HDR_W      = 4;
  localparam int MINLEN_W   = 8;
  localparam int IP_W       = 32;
  localparam int MAC_W      = 48;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int OUT_TDATA_W = 56;
  localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - MAC_W;

  localparam logic [STATUS_W-1:0] ST_MATCH     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ARP   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_REPLY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OTHER_IP  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_IP       = 2'd2;

  localparam logic [HDR_W-1:0]    HEADER_LENGTH_RST    = 4'd10;
  localparam logic [MINLEN_W-1:0] MIN_FRAME_LENGTH_RST = 8'd42;
  localparam logic [IP_W-1:0]     GATEWAY_IP_RST       = 32'h0A00_0202;
  localparam logic [MINLEN_W-1:0] LEAST_MIN_FRAME      = 8'd32;

  localparam int OFF_TYPE_HI = 12;
  localparam int OFF_TYPE_LO = 13;
  localparam int OFF_OP_HI   = 20;
  localparam int OFF_OP_LO   = 21;
  localparam int OFF_MAC_FST = 22;
  localparam int OFF_MAC_LST = 27;
  localparam int OFF_IP_FST  = 28;
  localparam int OFF_IP_LST  = 31;

  localparam logic [BYTE_W-1:0] ETH_TYPE_HI = 8'h08;
  localparam logic [BYTE_W-1:0] ETH_TYPE_LO = 8'h06;
  localparam logic [BYTE_W-1:0] ARP_OP_HI   = 8'h00;
  localparam logic [BYTE_W-1:0] ARP_OP_LO   = 8'h02;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MAC_W-1:0]    sender_mac;
  } result_t;

endpackage

### rtl/core/arp_reply_frame_filter_top.sv
// Top level of the ARP reply frame filter: configuration registers, input
// register, check stage and result register. Depends on arf_pkg,
// arf_in_reg, arf_check and assert_macros.svh.
//
//   channel  | direction | contents
//   s_*      | in        | one buffer byte per request, tlast on the final byte
//   m_*      | out       | one result per buffer: status and sender MAC
//   cfg_*    | in        | register writes, no handshake
//
// One byte is accepted every cycle while no stalled result holds a last byte back;
// the result of a buffer is offered once its last byte has passed the input
// register and the verdict sits in the result register.
// Reset is synchronous and returns the configuration registers to their defaults.
// A stalled result blocks only a following last byte; bytes before it keep flowing.
`include "assert_macros.svh"
module arp_reply_frame_filter_top import arf_pkg::*; #(
  parameter int MAX_BUFFER_BYTES = 2048
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] frame_byte
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [2:0] status, [50:3] sender_mac, rest zero
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [HDR_W-1:0]    header_length;
  logic [MINLEN_W-1:0] min_frame_length;
  logic [IP_W-1:0]     gateway_ip;

  logic    in_valid;
  item_t   item;
  logic    advance;
  result_t result;
  result_t res_q;
  logic    out_valid;
  logic    res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_length    <= HEADER_LENGTH_RST;
      min_frame_length <= MIN_FRAME_LENGTH_RST;
      gateway_ip       <= GATEWAY_IP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_LENGTH:    header_length    <= cfg_data[HDR_W-1:0];
        CFG_MIN_FRAME_LENGTH: min_frame_length <= cfg_data[MINLEN_W-1:0];
        CFG_GATEWAY_IP:       gateway_ip       <= cfg_data[IP_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = in_valid && (!item.last_byte || !out_valid || m_tready);
  assign res_load = advance && item.last_byte;

  arf_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .advance  (advance),
    .in_valid (in_valid),
    .item     (item)
  );

  arf_check #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_check (
    .clk              (clk),
    .rst              (rst),
    .fire             (advance),
    .item             (item),
    .header_length    (header_length),
    .min_frame_length (min_frame_length),
    .gateway_ip       (gateway_ip),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, res_q.sender_mac, res_q.status};

  `ARF_ASSERT(a_no_overwrite, res_load |-> !out_valid || m_tready)
  `ARF_ASSERT(a_fail_mac_zero, out_valid && res_q.status != ST_MATCH |-> res_q.sender_mac == '0)

endmodule

### rtl/core/arf_in_reg.sv
// Input register of the ARP reply filter: holds one accepted byte until the
// check stage takes it. Depends on arf_pkg.
module arf_in_reg import arf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] frame_byte
  input  logic                 s_tlast,
  input  logic                 advance,
  output logic                 in_valid,
  output item_t                item
);

  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.frame_byte <= s_tdata;
      item.last_byte  <= s_tlast;
    end
  end

endmodule

### rtl/core/arf_check.sv
// Frame check stage: byte counter, field checks, MAC capture and status.
// Depends on arf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module arf_check import arf_pkg::*; #(
  parameter int MAX_BUFFER_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  item_t               item,
  input  logic [HDR_W-1:0]    header_length,
  input  logic [MINLEN_W-1:0] min_frame_length,
  input  logic [IP_W-1:0]     gateway_ip,
  output result_t             result
);

  localparam int CNT_W = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int CMP_W = (CNT_W > MINLEN_W + 1) ? CNT_W : MINLEN_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BUFFER_BYTES);

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic             ethertype_ok;
  logic             ethertype_ok_next;
  logic             opcode_ok;
  logic             opcode_ok_next;
  logic             sender_ip_ok;
  logic             sender_ip_ok_next;
  logic [MAC_W-1:0] captured_mac;
  logic [MAC_W-1:0] captured_mac_next;

  logic [CNT_W-1:0]    offset;
  logic                in_frame;
  logic [CNT_W-1:0]    total;
  logic                eth_upd;
  logic                op_upd;
  logic                ip_upd;
  logic [MAC_W-1:0]    mac_upd;
  logic [BYTE_W-1:0]   ip_want;
  logic [MINLEN_W-1:0] min_len;
  logic [CMP_W-1:0]    need_len;
  logic                too_short;

  assign in_frame = byte_count >= CNT_W'(header_length);
  assign offset   = byte_count - CNT_W'(header_length);
  assign total    = (byte_count == CNT_MAX) ? byte_count : byte_count + CNT_W'(1);

  always_comb begin
    case (offset[1:0])
      2'd0:    ip_want = gateway_ip[31:24];
      2'd1:    ip_want = gateway_ip[23:16];
      2'd2:    ip_want = gateway_ip[15:8];
      default: ip_want = gateway_ip[7:0];
    endcase
  end

  always_comb begin
    eth_upd = ethertype_ok;
    op_upd  = opcode_ok;
    ip_upd  = sender_ip_ok;
    mac_upd = captured_mac;
    if (in_frame) begin
      if (offset == CNT_W'(OFF_TYPE_HI)) begin
        if (item.frame_byte != ETH_TYPE_HI) eth_upd = 1'b0;
      end else if (offset == CNT_W'(OFF_TYPE_LO)) begin
        if (item.frame_byte != ETH_TYPE_LO) eth_upd = 1'b0;
      end else if (offset == CNT_W'(OFF_OP_HI)) begin
        if (item.frame_byte != ARP_OP_HI) op_upd = 1'b0;
      end else if (offset == CNT_W'(OFF_OP_LO)) begin
        if (item.frame_byte != ARP_OP_LO) op_upd = 1'b0;
      end else if (offset >= CNT_W'(OFF_MAC_FST) && offset <= CNT_W'(OFF_MAC_LST)) begin
        mac_upd = {captured_mac[MAC_W-BYTE_W-1:0], item.frame_byte};
      end else if (offset >= CNT_W'(OFF_IP_FST) && offset <= CNT_W'(OFF_IP_LST)) begin
        if (item.frame_byte != ip_want) ip_upd = 1'b0;
      end
    end
  end

  assign min_len   = (min_frame_length < LEAST_MIN_FRAME) ? LEAST_MIN_FRAME : min_frame_length;
  assign need_len  = CMP_W'(header_length) + CMP_W'(min_len);
  assign too_short = CMP_W'(total) < need_len;

  always_comb begin
    if (too_short) begin
      result.status = ST_SHORT;
    end else if (!eth_upd) begin
      result.status = ST_NOT_ARP;
    end else if (!op_upd) begin
      result.status = ST_NOT_REPLY;
    end else if (!ip_upd) begin
      result.status = ST_OTHER_IP;
    end else begin
      result.status = ST_MATCH;
    end
    result.sender_mac = (result.status == ST_MATCH) ? mac_upd : '0;
  end

  always_comb begin
    byte_count_next   = byte_count;
    ethertype_ok_next = ethertype_ok;
    opcode_ok_next    = opcode_ok;
    sender_ip_ok_next = sender_ip_ok;
    captured_mac_next = captured_mac;
    if (fire) begin
      if (item.last_byte) begin
        byte_count_next   = '0;
        ethertype_ok_next = 1'b1;
        opcode_ok_next    = 1'b1;
        sender_ip_ok_next = 1'b1;
        captured_mac_next = '0;
      end else begin
        byte_count_next   = total;
        ethertype_ok_next = eth_upd;
        opcode_ok_next    = op_upd;
        sender_ip_ok_next = ip_upd;
        captured_mac_next = mac_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      ethertype_ok <= 1'b1;
      opcode_ok    <= 1'b1;
      sender_ip_ok <= 1'b1;
      captured_mac <= '0;
    end else begin
      byte_count   <= byte_count_next;
      ethertype_ok <= ethertype_ok_next;
      opcode_ok    <= opcode_ok_next;
      sender_ip_ok <= sender_ip_ok_next;
      captured_mac <= captured_mac_next;
    end
  end

  `ARF_ASSERT(a_cnt_sat, byte_count <= CNT_MAX)
  `ARF_ASSERT(a_clear_after_last, fire && item.last_byte |=> byte_count == '0 && ethertype_ok && opcode_ok && sender_ip_ok)
  `ARF_ASSERT(a_cnt_step, fire && !item.last_byte && byte_count != CNT_MAX |=> byte_count == $past(byte_count) + CNT_W'(1))
  `ARF_ASSERT(a_cnt_idle, !fire |=> byte_count == $past(byte_count))

endmodule
